// ===== rtl/png_scanline_unfilter_macros.svh =====
// ----------------------------------------------------------------------------
// png scanline unfilter assertion macros
// Concurrent assertion wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

`ifndef SYNTHESIS

// checked on every rising edge while out of reset
`define PSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define PSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PSU_ASSERT(lbl, prop, msg)

`define PSU_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, constants and the paeth predictor of the scanline unfilter.
// ----------------------------------------------------------------------------
package psu_pkg;

  // line buffer geometry
  localparam int MAX_ROW_BYTES = 4096;
  localparam int COL_W         = $clog2(MAX_ROW_BYTES);

  // register and field widths
  localparam int ROW_BYTES_W = 13;
  localparam int BPP_W       = 3;
  localparam int BPP_SEL_W   = 2;
  localparam int HIST_DEPTH  = 4;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES       = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 1'd1;

  // reset values of the registers
  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = 13'd4096;
  localparam logic [BPP_W-1:0]       BPP_RESET       = 3'd1;

  // filter type of a row, bad covers every code above paeth
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filter_t;

  // request on the stream input
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } psu_in_t;

  // request on the pixel output
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       last_of_row;
    logic       bad_filter;
  } psu_out_t;

  // one accepted byte held between the control and the reconstruction
  typedef struct packed {
    logic             is_filter;
    logic             first_row;
    logic             last;
    filter_t          filter;
    logic [COL_W-1:0] column;
    logic [7:0]       data;
  } psu_stage_t;

  // paeth predictor over left, above and above-left
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [7:0] pa;
    logic [7:0] pb;
    logic [8:0] sum_ab;
    logic [8:0] two_c;
    logic [8:0] pc;
    pa     = (b >= c) ? (b - c) : (c - b);
    pb     = (a >= c) ? (a - c) : (c - a);
    sum_ab = {1'b0, a} + {1'b0, b};
    two_c  = {c, 1'b0};
    pc     = (sum_ab >= two_c) ? (sum_ab - two_c) : (two_c - sum_ab);
    if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
      return a;
    end else if ({1'b0, pb} <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

// ===== rtl/psu_ram.sv =====
// ----------------------------------------------------------------------------
// psu_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held until the next enabled read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/psu_ctrl.sv =====
// ----------------------------------------------------------------------------
// psu_ctrl
// Config registers, row and column tracking, line buffer read issue and the
// input stage register.
// ----------------------------------------------------------------------------
`include "png_scanline_unfilter_macros.svh"

module psu_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_stall,
  input  psu_pkg::psu_in_t              byte_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                          stage_take,
  output logic                          stage_valid,
  output psu_pkg::psu_stage_t           stage,
  output logic [psu_pkg::BPP_SEL_W-1:0] bpp_sel,
  output logic                          ram_re,
  output logic [psu_pkg::COL_W-1:0]     ram_raddr
);

  logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes;
  logic [psu_pkg::BPP_W-1:0]       bytes_per_pixel;
  logic [psu_pkg::COL_W-1:0]       column;
  logic                            first_row;
  logic                            expect_filter_byte;

  logic                            accept;
  logic                            is_filter;
  logic                            first_eff;
  logic [psu_pkg::ROW_BYTES_W-1:0] len_eff;
  logic [psu_pkg::ROW_BYTES_W-1:0] col_plus;
  logic                            last;
  psu_pkg::filter_t                filter_code;
  psu_pkg::filter_t                row_filter;
  psu_pkg::filter_t                row_filter_next;
  logic [psu_pkg::COL_W-1:0]       column_next;
  logic                            first_row_next;
  logic                            expect_next;

  assign cfg_ready  = 1'b1;
  assign byte_stall = stage_valid && !stage_take;
  assign accept     = byte_valid && !byte_stall;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes       <= psu_pkg::ROW_BYTES_RESET;
      bytes_per_pixel <= psu_pkg::BPP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psu_pkg::REG_ROW_BYTES:       row_bytes <= cfg_data;
        psu_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[psu_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped row length and left neighbour select
  always_comb begin
    if (row_bytes == '0) begin
      len_eff = psu_pkg::ROW_BYTES_W'(1);
    end else if (row_bytes > psu_pkg::ROW_BYTES_W'(psu_pkg::MAX_ROW_BYTES)) begin
      len_eff = psu_pkg::ROW_BYTES_W'(psu_pkg::MAX_ROW_BYTES);
    end else begin
      len_eff = row_bytes;
    end
    if (bytes_per_pixel == '0) begin
      bpp_sel = '0;
    end else if (bytes_per_pixel > psu_pkg::BPP_W'(psu_pkg::HIST_DEPTH)) begin
      bpp_sel = psu_pkg::BPP_SEL_W'(psu_pkg::HIST_DEPTH - 1);
    end else begin
      bpp_sel = psu_pkg::BPP_SEL_W'(bytes_per_pixel - psu_pkg::BPP_W'(1));
    end
  end

  // classify the incoming byte and advance the row position
  always_comb begin
    is_filter   = byte_item.start_of_image || expect_filter_byte;
    first_eff   = byte_item.start_of_image || first_row;
    col_plus    = psu_pkg::ROW_BYTES_W'(column) + psu_pkg::ROW_BYTES_W'(1);
    last        = col_plus >= len_eff;
    filter_code = (byte_item.data_byte <= 8'd4) ?
                  psu_pkg::filter_t'(byte_item.data_byte[2:0]) : psu_pkg::FILT_BAD;

    row_filter_next = row_filter;
    column_next     = column;
    first_row_next  = first_row;
    expect_next     = expect_filter_byte;
    if (accept) begin
      if (is_filter) begin
        row_filter_next = filter_code;
        column_next     = '0;
        first_row_next  = first_eff;
        expect_next     = 1'b0;
      end else begin
        column_next    = last ? '0 : col_plus[psu_pkg::COL_W-1:0];
        first_row_next = last ? 1'b0 : first_row;
        expect_next    = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_filter         <= psu_pkg::FILT_NONE;
      column             <= '0;
      first_row          <= 1'b1;
      expect_filter_byte <= 1'b1;
    end else begin
      row_filter         <= row_filter_next;
      column             <= column_next;
      first_row          <= first_row_next;
      expect_filter_byte <= expect_next;
    end
  end

  // line buffer read for the byte above
  assign ram_re    = accept && !is_filter;
  assign ram_raddr = column;

  // input stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (stage_take) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.is_filter <= is_filter;
      stage.first_row <= first_row;
      stage.last      <= last;
      stage.filter    <= is_filter ? filter_code : row_filter;
      stage.column    <= column;
      stage.data      <= byte_item.data_byte;
    end
  end

  `PSU_ASSERT(a_filter_restarts_row, (stage_valid && stage.is_filter) |-> ((column == '0) && !expect_filter_byte), "filter byte did not restart the column")
  `PSU_ASSERT(a_last_expects_filter, (stage_valid && !stage.is_filter && stage.last) |-> expect_filter_byte, "row end did not arm the filter byte")
  `PSU_ASSERT(a_read_only_for_data, ram_re |-> (!expect_filter_byte && !byte_item.start_of_image), "line buffer read issued for a filter byte")

endmodule

// ===== rtl/psu_recon.sv =====
// ----------------------------------------------------------------------------
// psu_recon
// Predictor selection, byte reconstruction, neighbour history, line buffer
// write and the result register.
// ----------------------------------------------------------------------------
`include "png_scanline_unfilter_macros.svh"

module psu_recon (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          stage_valid,
  input  psu_pkg::psu_stage_t           stage,
  input  logic [psu_pkg::BPP_SEL_W-1:0] bpp_sel,
  input  logic [7:0]                    ram_rdata,
  output logic                          stage_take,
  output logic                          ram_we,
  output logic [psu_pkg::COL_W-1:0]     ram_waddr,
  output logic [7:0]                    ram_wdata,
  output logic                          pix_valid,
  input  logic                          pix_stall,
  output psu_pkg::psu_out_t             pix_item
);

  logic [7:0] left_hist  [psu_pkg::HIST_DEPTH];
  logic [7:0] above_hist [psu_pkg::HIST_DEPTH];

  logic       has_left;
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [8:0] avg_sum;
  logic [7:0] pred;
  logic [7:0] x;
  logic       retire_data;

  // a data byte in the stage moves on when the result register has room; a filter byte always moves on
  assign stage_take  = stage_valid && (stage.is_filter || !pix_valid || !pix_stall);
  assign retire_data = stage_take && !stage.is_filter;

  // neighbours: left and above-left are zero before the first pixel
  always_comb begin
    has_left = stage.column > psu_pkg::COL_W'(bpp_sel);
    a        = has_left ? left_hist[bpp_sel] : 8'd0;
    c        = has_left ? above_hist[bpp_sel] : 8'd0;
    b        = stage.first_row ? 8'd0 : ram_rdata;
    avg_sum  = {1'b0, a} + {1'b0, b};
  end

  // predictor by filter type, sum modulo 256
  always_comb begin
    case (stage.filter)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      psu_pkg::FILT_PAETH: pred = psu_pkg::paeth(a, b, c);
      default:             pred = 8'd0;
    endcase
    x = stage.data + pred;
  end

  // neighbour history, cleared by each filter byte
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < psu_pkg::HIST_DEPTH; k++) begin
        left_hist[k]  <= 8'd0;
        above_hist[k] <= 8'd0;
      end
    end else if (stage_take) begin
      if (stage.is_filter) begin
        for (int k = 0; k < psu_pkg::HIST_DEPTH; k++) begin
          left_hist[k]  <= 8'd0;
          above_hist[k] <= 8'd0;
        end
      end else begin
        for (int k = psu_pkg::HIST_DEPTH - 1; k > 0; k--) begin
          left_hist[k]  <= left_hist[k-1];
          above_hist[k] <= above_hist[k-1];
        end
        left_hist[0]  <= x;
        above_hist[0] <= b;
      end
    end
  end

  // reconstructed byte becomes the row above
  assign ram_we    = retire_data;
  assign ram_waddr = stage.column;
  assign ram_wdata = x;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (retire_data) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire_data) begin
      pix_item.pixel_byte  <= x;
      pix_item.last_of_row <= stage.last;
      pix_item.bad_filter  <= (stage.filter == psu_pkg::FILT_BAD);
    end
  end

  `PSU_ASSERT(a_filter_clears_history, (stage_take && stage.is_filter) |=> ((left_hist[0] == 8'd0) && (above_hist[0] == 8'd0)), "history not cleared at row start")
  `PSU_ASSERT(a_data_gives_result, retire_data |=> pix_valid, "data byte retired without a result")
  `PSU_ASSERT_ALWAYS(a_no_write_on_filter, ram_we |-> (stage_valid && !stage.is_filter), "line buffer written by a filter byte")

endmodule

// ===== rtl/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline reconstruction (None, Sub, Up, Average, Paeth) for 8-bit
// channels, one byte of the inflated stream per request.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while byte_stall is low; each data byte
// gives one reconstructed byte via the input stage register and the result
// register behind the reconstruction logic; the filter byte that opens each
// row gives none. The line buffer's registered read is issued on accept. The
// first row of an image (start_of_image on its filter byte) reads zero above;
// a filter type above 4 passes the row through and sets bad_filter. The user
// must write row_bytes and bytes_per_pixel on the cfg port only while no byte
// is in flight; the block does not enforce it. No clearing pass after reset.
module png_scanline_unfilter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  output logic                            byte_stall,
  input  psu_pkg::psu_in_t                byte_item,
  output logic                            pix_valid,
  input  logic                            pix_stall,
  output psu_pkg::psu_out_t               pix_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                          stage_take;
  logic                          stage_valid;
  psu_pkg::psu_stage_t           stage;
  logic [psu_pkg::BPP_SEL_W-1:0] bpp_sel;
  logic                          ram_re;
  logic [psu_pkg::COL_W-1:0]     ram_raddr;
  logic [7:0]                    ram_rdata;
  logic                          ram_we;
  logic [psu_pkg::COL_W-1:0]     ram_waddr;
  logic [7:0]                    ram_wdata;

  // row tracking and input stage
  psu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .stage_take (stage_take),
    .stage_valid(stage_valid),
    .stage      (stage),
    .bpp_sel    (bpp_sel),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr)
  );

  // previous reconstructed row
  psu_ram #(
    .WIDTH(8),
    .DEPTH(psu_pkg::MAX_ROW_BYTES)
  ) u_line_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // reconstruction and result register
  psu_recon u_recon (
    .clk        (clk),
    .rst        (rst),
    .stage_valid(stage_valid),
    .stage      (stage),
    .bpp_sel    (bpp_sel),
    .ram_rdata  (ram_rdata),
    .stage_take (stage_take),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix_item   (pix_item)
  );

endmodule
